### rtl/sm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types and constants for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sm3_out_t;

  // word handed from front to back: data plus "final word of padded message"
  typedef struct packed {
    logic [31:0] data;
    logic        final_word;
  } sm3_word_t;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [3:0]  LEN_SLOT = 4'd14;

  typedef enum logic [2:0] {
    F_IDLE, F_PAD1, F_ZERO, F_LENHI, F_LENLO
  } sm3_fstate_t;

  typedef enum logic [1:0] {
    B_LOAD, B_ROUND, B_EMIT
  } sm3_bstate_t;

  function automatic logic [31:0] iv(input logic [2:0] i);
    case (i)
      3'd0: iv = 32'h7380166F;
      3'd1: iv = 32'h4914B2B9;
      3'd2: iv = 32'h172442D7;
      3'd3: iv = 32'hDA8A0600;
      3'd4: iv = 32'hA96F30BC;
      3'd5: iv = 32'h163138AA;
      3'd6: iv = 32'hE38DEE4D;
      default: iv = 32'hB0FB0E4E;
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    rotl = (n == 5'd0) ? x : ((x << n) | (x >> (6'd32 - {1'b0, n})));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage

### rtl/sm3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_front
// Takes message items, counts length and emits padded 32-bit words.
// ----------------------------------------------------------------------------
module sm3_front import sm3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  sm3_in_t   din,
  output logic      wvalid,
  input  logic      wready,
  output sm3_word_t wout
);

  sm3_fstate_t state, state_next;
  logic [63:0] bit_length, bit_length_next;
  logic [3:0]  pos, pos_next;
  logic [31:0] w;
  logic        fin;
  logic [2:0]  k;
  logic [31:0] keep;
  logic        take;

  assign k = (din.byte_count > 3'd4) ? 3'd4 : din.byte_count;
  assign full = (state != F_IDLE) || !wready;
  assign take = push && !full;

  always_comb begin
    keep = 32'h0;
    case (k)
      3'd0: keep = 32'h00000000;
      3'd1: keep = 32'hFF000000;
      3'd2: keep = 32'hFFFF0000;
      3'd3: keep = 32'hFFFFFF00;
      default: keep = 32'hFFFFFFFF;
    endcase
  end

  always_comb begin
    state_next = state;
    bit_length_next = bit_length;
    pos_next = pos;
    w = 32'h0;
    fin = 1'b0;
    wvalid = 1'b0;
    case (state)
      F_IDLE: begin
        if (take) begin
          wvalid = 1'b1;
          if (!din.end_of_message) begin
            w = din.message_word;
            bit_length_next = bit_length + 64'd32;
          end else begin
            bit_length_next = bit_length + {58'd0, k, 3'd0};
            if (k == 3'd4) begin
              w = din.message_word;
              state_next = F_PAD1;
            end else begin
              w = (din.message_word & keep) | (PAD_WORD >> {k, 3'd0});
              state_next = (pos + 4'd1 == LEN_SLOT) ? F_LENHI : F_ZERO;
            end
          end
        end
      end
      F_PAD1: begin
        wvalid = 1'b1;
        w = PAD_WORD;
        if (wready) state_next = (pos + 4'd1 == LEN_SLOT) ? F_LENHI : F_ZERO;
      end
      F_ZERO: begin
        wvalid = 1'b1;
        if (wready && pos + 4'd1 == LEN_SLOT) state_next = F_LENHI;
      end
      F_LENHI: begin
        wvalid = 1'b1;
        w = bit_length[63:32];
        if (wready) state_next = F_LENLO;
      end
      F_LENLO: begin
        wvalid = 1'b1;
        w = bit_length[31:0];
        fin = 1'b1;
        if (wready) begin
          state_next = F_IDLE;
          bit_length_next = 64'd0;
        end
      end
      default: state_next = F_IDLE;
    endcase
    if (wvalid && wready) pos_next = pos + 4'd1;
  end

  assign wout.data = w;
  assign wout.final_word = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      bit_length <= 64'd0;
      pos <= 4'd0;
    end else begin
      state <= state_next;
      bit_length <= bit_length_next;
      pos <= pos_next;
    end
  end

endmodule

### rtl/sm3_wq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_wq
// Short word queue between front and back.
// ----------------------------------------------------------------------------
module sm3_wq import sm3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      ivalid,
  output logic      iready,
  input  sm3_word_t idata,
  output logic      ovalid,
  input  logic      oready,
  output sm3_word_t odata
);

  sm3_word_t mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;
  logic wr, rd;

  assign iready = (cnt != (QAW+1)'(QDEPTH));
  assign ovalid = (cnt != '0);
  assign odata  = mem[rp];
  assign wr = ivalid && iready;
  assign rd = ovalid && oready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= idata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

endmodule

### rtl/sm3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_back
// Fills the schedule window, runs 64 rounds per block, emits the digest.
// ----------------------------------------------------------------------------
module sm3_back import sm3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wvalid,
  output logic      wready,
  input  sm3_word_t win,
  output logic      empty,
  input  logic      pop,
  output sm3_out_t  dout
);

  sm3_bstate_t state, state_next;
  logic [31:0] v [8];
  logic [31:0] r [8];
  logic [31:0] wn [16];
  logic [3:0]  pos;
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic        fin;

  logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj, wnew;
  logic        lo;

  assign lo = (rnd < 6'd16);
  assign tj = lo ? T_LOW : T_HIGH;
  assign a12 = {r[0][19:0], r[0][31:20]};
  assign ss1 = rotl(a12 + r[4] + rotl(tj, rnd[4:0]), 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ffv = lo ? (r[0] ^ r[1] ^ r[2]) : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
  assign ggv = lo ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
  assign tt1 = ffv + r[3] + ss2 + (wn[0] ^ wn[4]);
  assign tt2 = ggv + r[7] + ss1 + wn[0];
  assign wnew = perm1(wn[0] ^ wn[7] ^ {wn[13][16:0], wn[13][31:17]})
              ^ {wn[3][24:0], wn[3][31:25]} ^ wn[10];

  assign wready = (state == B_LOAD);
  assign empty  = (state != B_EMIT);
  assign dout.digest_word = v[oidx];
  assign dout.word_index  = oidx;
  assign dout.last_word   = (oidx == 3'd7);

  always_comb begin
    state_next = state;
    case (state)
      B_LOAD:  if (wvalid && pos == 4'd15) state_next = B_ROUND;
      B_ROUND: if (rnd == 6'd63) state_next = fin ? B_EMIT : B_LOAD;
      B_EMIT:  if (pop && oidx == 3'd7) state_next = B_LOAD;
      default: state_next = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_LOAD && wvalid) wn[pos] <= win.data;
    if (state == B_ROUND) begin
      for (int i = 0; i < 15; i++) wn[i] <= wn[i+1];
      wn[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
      pos <= 4'd0;
      rnd <= 6'd0;
      oidx <= 3'd0;
      fin <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        v[i] <= iv(3'(i));
        r[i] <= 32'd0;
      end
    end else begin
      state <= state_next;
      case (state)
        B_LOAD: if (wvalid) begin
          pos <= pos + 4'd1;
          if (pos == 4'd15) begin
            fin <= win.final_word;
            rnd <= 6'd0;
            for (int i = 0; i < 8; i++) r[i] <= v[i];
          end
        end
        B_ROUND: begin
          r[3] <= r[2];
          r[2] <= {r[1][22:0], r[1][31:23]};
          r[1] <= r[0];
          r[0] <= tt1;
          r[7] <= r[6];
          r[6] <= {r[5][12:0], r[5][31:13]};
          r[5] <= r[4];
          r[4] <= perm0(tt2);
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            v[0] <= v[0] ^ tt1;
            v[1] <= v[1] ^ r[0];
            v[2] <= v[2] ^ {r[1][22:0], r[1][31:23]};
            v[3] <= v[3] ^ r[2];
            v[4] <= v[4] ^ perm0(tt2);
            v[5] <= v[5] ^ r[4];
            v[6] <= v[6] ^ {r[5][12:0], r[5][31:13]};
            v[7] <= v[7] ^ r[6];
          end
        end
        B_EMIT: if (pop) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7)
            for (int i = 0; i < 8; i++) v[i] <= iv(3'(i));
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/sm3_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine
// SM3 digest engine: padding front end, word queue, round back end.
// Each 16-word block is loaded into the schedule window, then runs 64 rounds while no words are taken.
// Synchronous active-high reset restores the IV and clears length and position.
// ----------------------------------------------------------------------------
module sm3_hash_engine import sm3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  sm3_in_t  din,
  output logic     empty,
  input  logic     pop,
  output sm3_out_t dout
);

  logic      fv, fr, bv, br;
  sm3_word_t fw, bw;

  sm3_front u_front (.clk, .rst, .push, .full, .din,
                     .wvalid(fv), .wready(fr), .wout(fw));
  sm3_wq    u_wq    (.clk, .rst, .ivalid(fv), .iready(fr), .idata(fw),
                     .ovalid(bv), .oready(br), .odata(bw));
  sm3_back  u_back  (.clk, .rst, .wvalid(bv), .wready(br), .win(bw),
                     .empty, .pop, .dout);

endmodule

### rtl/sm3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_checker
// Port-level checks for the SM3 hash engine.
// ----------------------------------------------------------------------------
module sm3_checker import sm3_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     push,
  input logic     full,
  input sm3_in_t  din,
  input logic     empty,
  input logic     pop,
  input sm3_out_t dout
);

  a_idx: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !dout.last_word) |=> (!empty && dout.word_index == $past(dout.word_index) + 3'd1))
    else $error("digest index did not advance");
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (dout.last_word == (dout.word_index == 3'd7)))
    else $error("last_word mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(dout)))
    else $error("result changed while stalled");
  a_rst: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result after reset");

endmodule

bind sm3_hash_engine sm3_checker u_chk (.*);
